FILE: src/iats_pkg.sv
package iats_pkg;

	localparam int MAX_CYLINDERS = 8;
	localparam int CYL_W = $clog2(MAX_CYLINDERS);

	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 72;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CYLINDER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = 2'd1;

	localparam logic [3:0] CYL_COUNT_RESET = 4'd4;
	localparam logic [31:0] TICKS_PER_SEC_RESET = 32'd1000000;

	localparam logic signed [17:0] CYCLE_FULL = 18'sd46080;
	localparam logic signed [17:0] CYCLE_HALF = 18'sd23040;
	localparam logic [15:0] CAM_HALF = 16'd23040;
	localparam logic [31:0] WRAP_HIGH = 32'd2863311531;
	localparam logic [31:0] WRAP_LOW = 32'd1431655765;
	localparam logic [31:0] TICK_MARGIN = 32'd5;
	localparam int DIV_BITS = 48;

	// x / 1e6 = ((x >> 6) * ceil(2^56 / 15625)) >> 56, exact for x below 2^48
	localparam int RECIP_SHIFT = 56;
	localparam logic [42:0] DWELL_RECIP = 43'((64'd1 << RECIP_SHIFT) / 64'd15625 + 64'd1);

	typedef enum logic [1:0] {
		ACT_KEEP = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_RESCHED = 2'd2
	} action_t;

	// TDC position in degrees, indexed by {cylinder count - 1, cylinder}
	localparam logic [9:0] TDC_DEG [64] = '{
		10'd0, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
		10'd0, 10'd360, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
		10'd0, 10'd240, 10'd480, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
		10'd0, 10'd180, 10'd360, 10'd540, 10'd0,   10'd0,   10'd0,   10'd0,
		10'd0, 10'd144, 10'd288, 10'd432, 10'd576, 10'd0,   10'd0,   10'd0,
		10'd0, 10'd120, 10'd240, 10'd360, 10'd480, 10'd600, 10'd0,   10'd0,
		10'd0, 10'd102, 10'd205, 10'd308, 10'd411, 10'd514, 10'd617, 10'd0,
		10'd0, 10'd90,  10'd180, 10'd270, 10'd360, 10'd450, 10'd540, 10'd630
	};

endpackage

FILE: src/ignition_angle_to_tick_scheduler_top.sv
// Ignition spark and dwell scheduler.
// Input stream (s_axis): one beat per scheduling request. Output stream
// (m_axis): one beat per cylinder, cylinder 0 upward, tlast on the beat for
// the final cylinder. Each beat says whether the cylinder was left alone
// (already dwelling), cancelled, or rescheduled with new fire and dwell ticks.
// Configuration: cfg_we/cfg_index/cfg_data write the cylinder count (index 0)
// and the timer tick rate (index 1); write only while the block is idle.
// Sequence: after the input beat, a shared multiply-accumulate turns the
// dwell time into ticks (reciprocal multiply for the division by a
// million); then each cylinder takes the check and the output step when
// left alone or cancelled, and when rescheduled the check, passes of the
// shared angle adder until the angle is in range, a multiply, two adds and
// the output step. s_axis_tready is high only between requests.
// Reset clears all dwell-start ticks to all ones, the cylinder count to 4
// and the tick rate to 1000000. When the receiver stalls, the output beat
// holds in its register and the sequencer waits before the next cylinder.
module ignition_angle_to_tick_scheduler_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// now_tick[31:0], cam_angle[47:32], cam_synced[48], ticks_per_degree[72:49],
	// spark_enable[73], advance_angle[89:74], dwell_us[105:90], zero pad
	input  logic [iats_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// cylinder_index[2:0], fire_tick[34:3], dwell_tick[66:35], zero pad
	output logic [iats_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// action[1:0]
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [iats_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [iats_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import iats_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIV   = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_WRAP  = 8'b0000_1000,
		ST_MUL   = 8'b0001_0000,
		ST_FIRE  = 8'b0010_0000,
		ST_DWELL = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [3:0]  cyl_count_q;
	logic [31:0] ticks_per_sec_q;
	logic [31:0] dwell_start_q [MAX_CYLINDERS];

	// request fields
	logic [31:0] now_q;
	logic [15:0] cam_q;
	logic        synced_q;
	logic [23:0] tpd_q;
	logic        enable_q;
	logic [15:0] advance_q;
	logic [CYL_W-1:0] last_cyl_q;

	// dwell-tick reciprocal multiply
	logic [DIV_BITS-7:0] div_q;
	logic [84:0]         recip_acc_q;
	logic [1:0]          step_q;

	// per-cylinder work
	logic [CYL_W-1:0]   cyl_q;
	logic signed [17:0] angle_q;
	logic [39:0]        prod_q;
	logic [31:0]        fire_q;
	logic [31:0]        dwell_q;
	action_t            action_q;

	// output register
	logic             m_valid_q;
	logic [CYL_W-1:0] m_cyl_q;
	logic [31:0]      m_fire_q;
	logic [31:0]      m_dwell_q;
	action_t          m_action_q;
	logic             m_last_q;

	logic        in_beat;
	logic        out_free;
	logic        emit_go;
	logic [3:0]  count_eff;
	logic [15:0] cam_in;
	logic [15:0] cam_adj;
	logic [DIV_BITS-1:0] dividend;
	logic [20:0] recip_a;
	logic [21:0] recip_b;
	logic [42:0] recip_pp;
	logic [84:0] recip_term;
	logic [31:0] margin_tick;
	logic [31:0] stored_tick;
	logic        not_dwelling;
	logic [9:0]  tdc_deg;
	logic signed [17:0] angle_init;
	logic signed [17:0] cycle_len;
	logic [31:0] dwell_ticks;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free = !m_valid_q || m_axis_tready;
	assign emit_go  = (state_q == ST_EMIT) && out_free;

	always_comb begin
		count_eff = cyl_count_q;
		if (cyl_count_q == 4'd0) begin
			count_eff = 4'd1;
		end else if (cyl_count_q > 4'(MAX_CYLINDERS)) begin
			count_eff = 4'(MAX_CYLINDERS);
		end
	end

	assign cam_in  = s_axis_tdata[47:32];
	assign cam_adj = (s_axis_tdata[48] && cam_in > CAM_HALF) ? cam_in - CAM_HALF : cam_in;
	assign dividend = {32'd0, s_axis_tdata[105:90]} * {16'd0, ticks_per_sec_q};

	// one 21x22 partial product of (dividend / 64) and the reciprocal per step
	assign recip_a  = step_q[1] ? div_q[41:21] : div_q[20:0];
	assign recip_b  = step_q[0] ? {1'b0, DWELL_RECIP[42:22]} : DWELL_RECIP[21:0];
	assign recip_pp = recip_a * recip_b;

	always_comb begin
		unique case (step_q)
			2'd0: recip_term = 85'(recip_pp);
			2'd1: recip_term = 85'(recip_pp) << 22;
			2'd2: recip_term = 85'(recip_pp) << 21;
			2'd3: recip_term = 85'(recip_pp) << 43;
		endcase
	end

	assign dwell_ticks = 32'(recip_acc_q[84:RECIP_SHIFT]);

	assign margin_tick  = now_q + TICK_MARGIN;
	assign stored_tick  = dwell_start_q[cyl_q];
	assign not_dwelling = (margin_tick < stored_tick) ||
		(margin_tick >= WRAP_HIGH && stored_tick < WRAP_LOW);

	assign tdc_deg    = TDC_DEG[{last_cyl_q, cyl_q}];
	assign angle_init = $signed({2'b00, tdc_deg, 6'd0}) - 18'(signed'(advance_q))
		- $signed({2'b00, cam_q});
	assign cycle_len  = synced_q ? CYCLE_FULL : CYCLE_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_count_q     <= CYL_COUNT_RESET;
			ticks_per_sec_q <= TICKS_PER_SEC_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_CYLINDER_COUNT) begin
				cyl_count_q <= cfg_data[3:0];
			end else if (cfg_index == REG_TICKS_PER_SEC) begin
				ticks_per_sec_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cyl_q   <= '0;
			step_q  <= '0;
			for (int i = 0; i < MAX_CYLINDERS; i++) begin
				dwell_start_q[i] <= '1;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						cyl_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (not_dwelling && enable_q) begin
						state_q <= ST_WRAP;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_WRAP: begin
					if (!angle_q[17] && angle_q <= cycle_len) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIRE;
				end
				ST_FIRE: begin
					state_q <= ST_DWELL;
				end
				ST_DWELL: begin
					dwell_start_q[cyl_q] <= fire_q - dwell_ticks;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (cyl_q == last_cyl_q) begin
							state_q <= ST_IDLE;
						end else begin
							cyl_q   <= cyl_q + 1'b1;
							state_q <= ST_CHECK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					now_q       <= s_axis_tdata[31:0];
					cam_q       <= cam_adj;
					synced_q    <= s_axis_tdata[48];
					tpd_q       <= s_axis_tdata[72:49];
					enable_q    <= s_axis_tdata[73];
					advance_q   <= s_axis_tdata[89:74];
					last_cyl_q  <= CYL_W'(count_eff - 4'd1);
					div_q       <= dividend[DIV_BITS-1:6];
					recip_acc_q <= '0;
				end
			end
			ST_DIV: begin
				recip_acc_q <= recip_acc_q + recip_term;
			end
			ST_CHECK: begin
				angle_q <= angle_init;
				fire_q  <= '0;
				dwell_q <= '0;
				if (!not_dwelling) begin
					action_q <= ACT_KEEP;
				end else if (!enable_q) begin
					action_q <= ACT_CANCEL;
				end else begin
					action_q <= ACT_RESCHED;
				end
			end
			ST_WRAP: begin
				// bring the angle into 0..cycle, keeping a full cycle as is
				if (angle_q[17]) begin
					angle_q <= angle_q + cycle_len;
				end else if (angle_q > cycle_len) begin
					angle_q <= angle_q - cycle_len;
				end
			end
			ST_MUL: begin
				prod_q <= tpd_q * angle_q[15:0];
			end
			ST_FIRE: begin
				fire_q <= now_q + prod_q[37:6];
			end
			ST_DWELL: begin
				dwell_q <= fire_q - dwell_ticks;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_cyl_q    <= cyl_q;
			m_action_q <= action_q;
			m_fire_q   <= fire_q;
			m_dwell_q  <= dwell_q;
			m_last_q   <= (cyl_q == last_cyl_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {(OUT_DATA_W - 2*32 - CYL_W)'(0), m_dwell_q, m_fire_q, m_cyl_q};
	assign m_axis_tuser  = m_action_q;
	assign m_axis_tlast  = m_last_q;

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_axis_tready)
		else $error("input taken twice in a row");

	a_wrap_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (!angle_q[17] && angle_q <= cycle_len))
		else $error("angle out of cycle at multiply");

	a_quiet_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_action_q != ACT_RESCHED) |-> (m_fire_q == '0 && m_dwell_q == '0))
		else $error("ticks set on a beat that does not reschedule");

	a_cyl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !s_axis_tready) |-> (m_cyl_q <= last_cyl_q))
		else $error("cylinder beyond count");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DWELL) |=> (dwell_start_q[$past(cyl_q)] == dwell_q))
		else $error("dwell start store out of step with result");

endmodule

FILE: tb/tb.sv
module tb;
	import iats_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int N_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT = 40;

	// packed so that now_tick lands in the lowest bits of tdata
	typedef struct packed {
		logic [15:0] dwell_us;
		logic [15:0] advance;
		logic        enable;
		logic [23:0] tpd;
		logic        synced;
		logic [15:0] cam;
		logic [31:0] now;
	} spark_request_t;

	typedef struct {
		logic [2:0]  cyl;
		action_t     action;
		logic [31:0] fire;
		logic [31:0] dwell;
		logic        last;
	} spark_result_t;

	class spark_scoreboard;
		logic [31:0]   dwell_start [MAX_CYLINDERS];
		logic [3:0]    cyl_count;
		logic [31:0]   tick_rate;
		spark_result_t expected_beats [$];
		int            errors;
		int            n_requests;
		int            n_beats;
		int            n_keep;
		int            n_cancel;
		int            n_resched;

		function new();
			foreach (dwell_start[i]) dwell_start[i] = '1;
			cyl_count = CYL_COUNT_RESET;
			tick_rate = TICKS_PER_SEC_RESET;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			case (idx)
				REG_CYLINDER_COUNT: cyl_count = val[3:0];
				REG_TICKS_PER_SEC:  tick_rate = val;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return expected_beats.size();
		endfunction

		// work out every cylinder's beat for one accepted request
		function void note_request(spark_request_t req);
			int unsigned   n;
			int            cam_pos;
			int            cycle;
			int            tdc;
			int            ang;
			logic [63:0]   prod;
			logic [31:0]   c;
			logic [31:0]   dwell_ticks;
			logic [31:0]   fire;
			spark_result_t r;
			n = cyl_count;
			if (n == 0)
				n = 1;
			if (n > MAX_CYLINDERS)
				n = MAX_CYLINDERS;
			cam_pos = int'(req.cam);
			cycle = req.synced ? int'(CYCLE_FULL) : int'(CYCLE_HALF);
			if (req.synced && cam_pos > int'(CAM_HALF))
				cam_pos -= int'(CAM_HALF);
			prod = 64'(req.dwell_us) * 64'(tick_rate);
			dwell_ticks = 32'(prod / 64'd1000000);
			c = req.now + TICK_MARGIN;
			n_requests++;
			for (int unsigned k = 0; k < n; k++) begin
				r.cyl = 3'(k);
				r.action = ACT_KEEP;
				r.fire = '0;
				r.dwell = '0;
				r.last = (k == n - 1);
				// pending when the dwell tick is still ahead, allowing for timer wrap
				if (c < dwell_start[k] || (c >= WRAP_HIGH && dwell_start[k] < WRAP_LOW)) begin
					if (!req.enable) begin
						r.action = ACT_CANCEL;
					end else begin
						tdc = int'((k * 720) / n) * 64;
						ang = tdc - int'($signed(req.advance)) - cam_pos;
						while (ang < 0)
							ang += cycle;
						// a full cycle is kept as it is
						while (ang > cycle)
							ang -= cycle;
						prod = 64'(req.tpd) * 64'(ang);
						fire = req.now + prod[37:6];
						r.action = ACT_RESCHED;
						r.fire = fire;
						r.dwell = fire - dwell_ticks;
						dwell_start[k] = r.dwell;
					end
				end
				case (r.action)
					ACT_KEEP:   n_keep++;
					ACT_CANCEL: n_cancel++;
					default:    n_resched++;
				endcase
				expected_beats.push_back(r);
			end
		endfunction

		task report(string what);
			if (errors < PRINT_LIMIT)
				$display("mismatch at beat %0d: %s", n_beats, what);
			errors++;
		endtask

		task check_beat(spark_result_t got);
			spark_result_t want;
			n_beats++;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected beat for cylinder %0d", got.cyl));
			end else begin
				want = expected_beats.pop_front();
				if (got.cyl !== want.cyl)
					report($sformatf("cylinder got %0d want %0d", got.cyl, want.cyl));
				if (got.action !== want.action)
					report($sformatf("cyl %0d action got %0d want %0d",
						want.cyl, got.action, want.action));
				if (got.fire !== want.fire)
					report($sformatf("cyl %0d fire got %h want %h",
						want.cyl, got.fire, want.fire));
				if (got.dwell !== want.dwell)
					report($sformatf("cyl %0d dwell got %h want %h",
						want.cyl, got.dwell, want.dwell));
				if (got.last !== want.last)
					report($sformatf("cyl %0d tlast got %b want %b",
						want.cyl, got.last, want.last));
			end
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   m_tready = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	spark_scoreboard sb = new();
	spark_result_t   got_beat;
	logic [31:0]     timeline = '0;
	bit              no_idle = 1'b0;
	int              rx_wait = 0;
	int              idle_cycles = 0;

	logic [31:0] phase_count [N_PHASES] = '{
		32'd8, 32'd1, 32'd0, 32'd15, 32'd7, 32'd3, 32'hFFFF_FFF5, 32'd6, 32'h10, 32'd2
	};
	logic [31:0] phase_rate [N_PHASES] = '{
		32'd1000000, 32'd1, 32'hFFFF_FFFF, 32'd32768000, 32'd40000000,
		32'd1000000, 32'd12345678, 32'd80000000, 32'd2000, 32'd999999
	};
	logic [31:0] phase_start [N_PHASES] = '{
		32'h0000_0000, 32'h0123_4567, 32'hFFFF_0000, 32'h3000_0000, 32'h7FFF_F000,
		32'hAAAA_A000, 32'h5555_5000, 32'hFFFF_C000, 32'hC000_0000, 32'hFFFE_8000
	};

	ignition_angle_to_tick_scheduler_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// receiver: check each beat, then hold off for a random stall
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_axis_tvalid && m_tready) begin
				got_beat.cyl = m_axis_tdata[2:0];
				got_beat.fire = m_axis_tdata[34:3];
				got_beat.dwell = m_axis_tdata[66:35];
				got_beat.action = action_t'(m_axis_tuser);
				got_beat.last = m_axis_tlast;
				sb.check_beat(got_beat);
				rx_wait = no_idle ? 0 : $urandom_range(0, 13);
			end
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d beats still due",
				idle_cycles, sb.outstanding());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic spark_request_t mk(logic [31:0] now, logic [15:0] cam, logic synced,
			logic [23:0] tpd, logic en, logic [15:0] adv, logic [15:0] dwell);
		spark_request_t q;
		q.now = now;
		q.cam = cam;
		q.synced = synced;
		q.tpd = tpd;
		q.enable = en;
		q.advance = adv;
		q.dwell_us = dwell;
		return q;
	endfunction

	// mostly a running engine timeline, now and then an arbitrary tick
	function automatic spark_request_t random_request();
		spark_request_t q;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 6)
			timeline += $urandom_range(0, 200000);
		else
			timeline += $urandom_range(0, 3000);
		q.now = (sel == 9) ? $urandom : timeline;
		q.cam = $urandom_range(0, 46079);
		q.synced = $urandom_range(0, 1);
		q.tpd = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 300));
		q.enable = ($urandom_range(0, 7) != 0);
		q.advance = ($urandom_range(0, 5) == 0) ? 16'($urandom)
			: 16'(int'($urandom_range(0, 4480)) - 640);
		q.dwell_us = ($urandom_range(0, 7) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, 6000));
		return q;
	endfunction

	task automatic send_request(spark_request_t req);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_DATA_W'(req);
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(req);
	endtask

	// drop valid and wait until every due beat has arrived
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values; store starts all ones
		send_request(mk(32'h0, 16'd0, 1'b0, 24'd0, 1'b0, 16'h0, 16'd0));
		send_request(mk(32'hFFFF_FFFA, 16'd46079, 1'b1, 24'hFF_FFFF, 1'b1, 16'h7FFF, 16'hFFFF));
		send_request(mk(32'h100, 16'd0, 1'b0, 24'd1, 1'b1, 16'h0, 16'd0));
		send_request(mk(32'h100, 16'd0, 1'b0, 24'd1, 1'b1, 16'h0, 16'd0));
		send_request(mk(32'h1000, 16'd23040, 1'b1, 24'd100, 1'b1, 16'h8000, 16'hFFFF));
		send_request(mk(32'h2000, 16'd23041, 1'b1, 24'd100, 1'b1, 16'h7FFF, 16'd1000));
		// advance puts cylinder 0 exactly one cycle out
		send_request(mk(32'h3000, 16'd0, 1'b0, 24'd64, 1'b1, 16'hA600, 16'd0));
		send_request(mk(32'h4000, 16'd46079, 1'b0, 24'd64, 1'b1, 16'h7FFF, 16'd10));
		send_request(mk(32'h1000_0000, 16'd100, 1'b1, 24'hFF_FFFF, 1'b1, 16'h0, 16'hFFFF));
		send_request(mk(32'h1000_0000, 16'd0, 1'b1, 24'd50, 1'b0, 16'h0, 16'd0));
		send_request(mk(32'hFFFF_FF00, 16'd0, 1'b1, 24'd10, 1'b1, 16'h0, 16'd0));
		send_request(mk(32'hFFFF_FFF0, 16'd8000, 1'b0, 24'd10, 1'b1, 16'hFF00, 16'd200));
		send_request(mk(32'hFFFF_FFFF, 16'd0, 1'b1, 24'd0, 1'b1, 16'h0, 16'd0));
		send_request(mk(32'h0, 16'd46079, 1'b1, 24'hFF_FFFF, 1'b1, 16'h8000, 16'hFFFF));
		send_request(mk(32'h0, 16'd46079, 1'b0, 24'd0, 1'b0, 16'h7FFF, 16'hFFFF));
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(REG_CYLINDER_COUNT, phase_count[p]);
			write_reg(REG_TICKS_PER_SEC, phase_rate[p]);
			if (p == 0 || $urandom_range(0, 1))
				write_reg(REG_SPARE, $urandom);
			cfg_we <= 1'b0;
			timeline = phase_start[p];
			no_idle = (p == 3 || p == 7);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 15) == 0)
					settle();
				send_request(random_request());
			end
			settle();
		end

		repeat (150) @(posedge clk);
		$display("%0d requests over %0d register settings, %0d beats checked",
			sb.n_requests, N_PHASES + 1, sb.n_beats);
		$display("beats kept %0d, cancelled %0d, rescheduled %0d, mismatches %0d",
			sb.n_keep, sb.n_cancel, sb.n_resched, sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
src/iats_pkg.sv
src/ignition_angle_to_tick_scheduler_top.sv
tb/tb.sv
